FILE: src/assert_macros.svh
// Assertion macros shared by the hash core modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Check that cond holds at every edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

FILE: src/wmh_pkg.sv
// Types, constants and helper functions of the word modular hash core
package wmh_pkg;

  localparam int MAX_PAIRS  = 32;
  localparam int PAIR_W     = $clog2(MAX_PAIRS + 1);
  localparam int CODE_W     = 6;
  localparam int DIGIT_W    = 2 * CODE_W;
  localparam int DIGIT_SHIFT = 12;
  localparam int RES_W      = 14;
  localparam int MUL_W      = RES_W + 2;
  localparam int PROD_W     = DIGIT_W + RES_W;
  localparam int RED_STEPS  = 14;
  localparam int VAL_W      = 2 * RED_STEPS;
  localparam int STEP_W     = $clog2(RED_STEPS);
  localparam int LPW_W      = 4;
  localparam int HW_W       = 6;
  localparam int HASH_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_MODULUS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_MODULUS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_PART_WIDTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_WIDTH     = 2'd3;

  localparam logic [RES_W-1:0] LOW_MODULUS_RST    = 14'd8191;
  localparam logic [RES_W-1:0] HIGH_MODULUS_RST   = 14'd16381;
  localparam logic [LPW_W-1:0] LOW_PART_WIDTH_RST = 4'd13;
  localparam logic [HW_W-1:0]  HASH_WIDTH_RST     = 6'd27;

  localparam logic [RES_W-1:0] LOW_WEIGHT_RST  = 14'd1;
  localparam logic [RES_W-1:0] HIGH_WEIGHT_RST = 14'd8;

  localparam logic [7:0] FIRST_MAPPED = 8'h20;
  localparam logic [6:0] NO_CODE      = 7'd64;
  localparam int TABLE_DEPTH = 96;

  localparam logic [6:0] CODE_TABLE [TABLE_DEPTH] = '{
    NO_CODE, NO_CODE, NO_CODE, NO_CODE, NO_CODE, NO_CODE, 7'd0,  7'd31,
    NO_CODE, NO_CODE, NO_CODE, NO_CODE, NO_CODE, NO_CODE, NO_CODE, NO_CODE,
    7'd2,  7'd25, 7'd20, 7'd35, 7'd54, 7'd61, 7'd40, 7'd39,
    7'd42, 7'd33, NO_CODE, NO_CODE, NO_CODE, NO_CODE, NO_CODE, NO_CODE,
    NO_CODE, 7'd60, 7'd43, 7'd30, 7'd5,  7'd16, 7'd47, 7'd18,
    7'd41, 7'd36, 7'd51, 7'd6,  7'd13, 7'd56, 7'd55, 7'd58,
    7'd49, 7'd12, 7'd59, 7'd46, 7'd21, 7'd32, 7'd63, 7'd34,
    7'd57, 7'd52, 7'd3,  NO_CODE, NO_CODE, NO_CODE, NO_CODE, NO_CODE,
    NO_CODE, 7'd22, 7'd29, 7'd8,  7'd7,  7'd10, 7'd1,  7'd28,
    7'd11, 7'd62, 7'd37, 7'd48, 7'd15, 7'd50, 7'd9,  7'd4,
    7'd19, 7'd38, 7'd45, 7'd24, 7'd23, 7'd26, 7'd17, 7'd44,
    7'd27, 7'd14, 7'd53, NO_CODE, NO_CODE, NO_CODE, NO_CODE, NO_CODE
  };

  typedef struct packed {
    logic                has_digit;
    logic [DIGIT_W-1:0]  digit;
    logic                finish;
    logic                trash;
  } wmh_op_t;

  typedef struct packed {
    logic [RES_W-1:0] low_modulus;
    logic [RES_W-1:0] high_modulus;
    logic [LPW_W-1:0] low_part_width;
    logic [HW_W-1:0]  hash_width;
  } wmh_cfg_t;

  function automatic logic [6:0] code_lookup(input logic [7:0] b);
    logic [7:0] idx;
    idx = b - FIRST_MAPPED;
    if (b < FIRST_MAPPED || b[7]) begin
      return NO_CODE;
    end
    return CODE_TABLE[idx[6:0]];
  endfunction

  function automatic logic [MUL_W-1:0] eff_modulus(input logic [RES_W-1:0] m);
    return (m == '0) ? MUL_W'(1) : {2'b00, m};
  endfunction

  function automatic logic [RES_W-1:0] reduce_step(input logic [MUL_W-1:0] t,
                                                   input logic [MUL_W-1:0] m1,
                                                   input logic [MUL_W-1:0] m2,
                                                   input logic [MUL_W-1:0] m3);
    logic [MUL_W-1:0] r;
    r = t;
    if (t >= m3) begin
      r = t - m3;
    end else if (t >= m2) begin
      r = t - m2;
    end else if (t >= m1) begin
      r = t - m1;
    end
    return r[RES_W-1:0];
  endfunction

  function automatic logic [HASH_W-1:0] trash_value(input logic [HW_W-1:0] hw);
    logic [HW_W-1:0]   w;
    logic [HASH_W:0]   one_sh;
    logic [HASH_W:0]   diff;
    w = (hw > HW_W'(HASH_W)) ? HW_W'(HASH_W) : hw;
    one_sh = (HASH_W+1)'(1) << w;
    diff = one_sh - (HASH_W+1)'(1);
    return diff[HASH_W-1:0];
  endfunction

endpackage

FILE: src/wmh_front.sv
// Front end: accept bytes, pair codes into digits, track trash and pair count
`include "assert_macros.svh"

module wmh_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,
  input  logic             s_tlast,
  input  logic             q_full,
  output logic             push,
  output wmh_pkg::wmh_op_t push_op
);
  import wmh_pkg::*;

  logic [CODE_W-1:0] pending_code, pending_code_next;
  logic              have_pending, have_pending_next;
  logic [PAIR_W-1:0] pair_count, pair_count_next;
  logic              trash_seen, trash_seen_next;
  logic [6:0]        code_first, code_second;
  logic              accept;
  wmh_op_t           op;

  assign s_tready    = !q_full;
  assign accept      = s_tvalid && s_tready;
  assign code_first  = code_lookup(s_tdata);
  assign code_second = code_lookup({1'b0, s_tdata[6:0]});

  always_comb begin
    pending_code_next = pending_code;
    have_pending_next = have_pending;
    pair_count_next   = pair_count;
    trash_seen_next   = trash_seen;
    op                = '0;
    if (!trash_seen) begin
      if (have_pending) begin
        if (s_tdata[6:0] == 7'd0) begin
          // lone pending code forms a digit; masked zero never maps
          op.has_digit      = 1'b1;
          op.digit          = {{CODE_W{1'b0}}, pending_code};
          pair_count_next   = pair_count + PAIR_W'(1);
          have_pending_next = 1'b0;
          if (pair_count_next < PAIR_W'(MAX_PAIRS)) begin
            trash_seen_next = 1'b1;
          end
        end else if (code_second == NO_CODE) begin
          trash_seen_next = 1'b1;
        end else begin
          op.has_digit      = 1'b1;
          op.digit          = {code_second[CODE_W-1:0], pending_code};
          pair_count_next   = pair_count + PAIR_W'(1);
          have_pending_next = 1'b0;
        end
      end else if (pair_count < PAIR_W'(MAX_PAIRS)) begin
        if (code_first == NO_CODE) begin
          trash_seen_next = 1'b1;
        end else begin
          pending_code_next = code_first[CODE_W-1:0];
          have_pending_next = 1'b1;
        end
      end
    end
    if (s_tlast) begin
      if (!trash_seen_next && have_pending_next) begin
        op.has_digit = 1'b1;
        op.digit     = {{CODE_W{1'b0}}, pending_code_next};
      end
      op.finish = 1'b1;
      op.trash  = trash_seen_next;
    end
  end

  assign push    = accept && (op.has_digit || op.finish);
  assign push_op = op;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_code <= '0;
      have_pending <= 1'b0;
      pair_count   <= '0;
      trash_seen   <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        pending_code <= '0;
        have_pending <= 1'b0;
        pair_count   <= '0;
        trash_seen   <= 1'b0;
      end else begin
        pending_code <= pending_code_next;
        have_pending <= have_pending_next;
        pair_count   <= pair_count_next;
        trash_seen   <= trash_seen_next;
      end
    end
  end

  `ASSERT_ALWAYS(a_pair_bound, clk, rst, pair_count <= PAIR_W'(MAX_PAIRS), "pair count overrun")

endmodule

FILE: src/wmh_queue.sv
// Short queue of digit and end-of-word operations between front and back
`include "assert_macros.svh"

module wmh_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  wmh_pkg::wmh_op_t push_op,
  input  logic             pop,
  output wmh_pkg::wmh_op_t head,
  output logic             full,
  output logic             empty
);
  import wmh_pkg::*;

  wmh_op_t           slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  `ASSERT_SAME(a_no_overflow, clk, rst, push, !full || pop, "push into full queue")
  `ASSERT_SAME(a_no_underflow, clk, rst, pop, !empty, "pop from empty queue")

endmodule

FILE: src/wmh_back.sv
// Back end: modular multiply-accumulate of digits and result output register
`include "assert_macros.svh"

module wmh_back (
  input  logic                      clk,
  input  logic                      rst,
  input  wmh_pkg::wmh_cfg_t         cfg,
  input  wmh_pkg::wmh_op_t          head,
  input  logic                      empty,
  output logic                      pop,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [wmh_pkg::HASH_W-1:0] m_tdata,
  output logic                      m_tuser
);
  import wmh_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_ADD  = 6'b000100,
    ST_RED  = 6'b001000,
    ST_WB   = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t            state;
  wmh_op_t           op;
  logic [RES_W-1:0]  lo_sum, hi_sum, lo_w, hi_w;
  logic [PROD_W-1:0] prod_lo, prod_hi;
  logic [MUL_W-1:0]  mod1 [2];
  logic [MUL_W-1:0]  mod2 [2];
  logic [MUL_W-1:0]  mod3 [2];
  logic [VAL_W-1:0]  val [4];
  logic [RES_W-1:0]  rem [4];
  logic [STEP_W-1:0] step;
  logic              out_valid;
  logic [HASH_W-1:0] out_hash;
  logic              out_trash;
  logic              out_free;

  assign pop      = (state == ST_IDLE) && !empty;
  assign out_free = !out_valid || m_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_hash;
  assign m_tuser  = out_trash;

  // lanes: 0 low sum, 1 high sum, 2 low weight, 3 high weight
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (!empty) begin
          op <= head;
        end
      end
      ST_MUL: begin
        prod_lo <= PROD_W'(op.digit) * PROD_W'(lo_w);
        prod_hi <= PROD_W'(op.digit) * PROD_W'(hi_w);
        mod1[0] <= eff_modulus(cfg.low_modulus);
        mod1[1] <= eff_modulus(cfg.high_modulus);
        mod2[0] <= eff_modulus(cfg.low_modulus) << 1;
        mod2[1] <= eff_modulus(cfg.high_modulus) << 1;
        mod3[0] <= eff_modulus(cfg.low_modulus) + (eff_modulus(cfg.low_modulus) << 1);
        mod3[1] <= eff_modulus(cfg.high_modulus) + (eff_modulus(cfg.high_modulus) << 1);
      end
      ST_ADD: begin
        val[0] <= VAL_W'(lo_sum) + VAL_W'(prod_lo);
        val[1] <= VAL_W'(hi_sum) + VAL_W'(prod_hi);
        val[2] <= VAL_W'({lo_w, {DIGIT_SHIFT{1'b0}}});
        val[3] <= VAL_W'({hi_w, {DIGIT_SHIFT{1'b0}}});
        for (int i = 0; i < 4; i++) begin
          rem[i] <= '0;
        end
        step <= '0;
      end
      ST_RED: begin
        for (int i = 0; i < 4; i++) begin
          rem[i] <= reduce_step({rem[i], val[i][VAL_W-1 -: 2]},
                                mod1[1'(i)], mod2[1'(i)], mod3[1'(i)]);
          val[i] <= val[i] << 2;
        end
        step <= step + STEP_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      lo_sum    <= '0;
      hi_sum    <= '0;
      lo_w      <= LOW_WEIGHT_RST;
      hi_w      <= HIGH_WEIGHT_RST;
    end else begin
      if (out_valid && m_tready && state != ST_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!empty) begin
            state <= head.has_digit ? ST_MUL : ST_FIN;
          end
        end
        ST_MUL: state <= ST_ADD;
        ST_ADD: state <= ST_RED;
        ST_RED: begin
          if (step == STEP_W'(RED_STEPS - 1)) begin
            state <= ST_WB;
          end
        end
        ST_WB: begin
          lo_sum <= rem[0];
          hi_sum <= rem[1];
          lo_w   <= rem[2];
          hi_w   <= rem[3];
          state  <= op.finish ? ST_FIN : ST_IDLE;
        end
        ST_FIN: begin
          // hold until the output register can take the beat
          if (out_free) begin
            out_valid <= 1'b1;
            out_trash <= op.trash;
            if (op.trash) begin
              out_hash <= trash_value(cfg.hash_width);
            end else begin
              out_hash <= HASH_W'(lo_sum) | (HASH_W'(hi_sum) << cfg.low_part_width);
            end
            lo_sum <= '0;
            hi_sum <= '0;
            lo_w   <= LOW_WEIGHT_RST;
            hi_w   <= HIGH_WEIGHT_RST;
            state  <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_lo_reduced, clk, rst, state == ST_WB, {2'b00, lo_sum} < mod1[0],
               "low residue not reduced")
  `ASSERT_NEXT(a_hi_w_reduced, clk, rst, state == ST_WB, {2'b00, hi_w} < mod1[1],
               "high weight not reduced")
  `ASSERT_NEXT(a_fin_hold, clk, rst, state == ST_FIN && out_valid && !m_tready,
               state == ST_FIN && out_valid, "result dropped while output busy")

endmodule

FILE: src/word_modular_hash_core.sv
// Top level of the word modular hash core: configuration registers and wiring
//
// Hashes a word arriving one byte per beat on the slave stream; the beat with tlast
// set yields one result beat (hash value in tdata, trash flag in tuser). The front end
// takes a byte every cycle while the queue has room, into a four-entry operation queue.
// Each digit, a completed code pair or a lone code, passes through the back end as a
// dispatch, a multiply, an add, fourteen two-bit steps of the modular reducer and a
// write-back; the end of a word waits in a finish state for the output register.
// The reducer loop bounds the sustained rate; the back end takes one digit at a time.
// No clearing pass follows reset. Write configuration only while no word is in flight.
`include "assert_macros.svh"

module word_modular_hash_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] char_code
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [wmh_pkg::HASH_W-1:0]    m_tdata,   // [31:0] hash_value
  output logic                          m_tuser,   // [0] is_trash
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wmh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wmh_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wmh_pkg::*;

  wmh_cfg_t cfg;
  wmh_op_t  push_op;
  wmh_op_t  head;
  logic     push, pop, q_full, q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_modulus    <= LOW_MODULUS_RST;
      cfg.high_modulus   <= HIGH_MODULUS_RST;
      cfg.low_part_width <= LOW_PART_WIDTH_RST;
      cfg.hash_width     <= HASH_WIDTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LOW_MODULUS:    cfg.low_modulus    <= cfg_data[RES_W-1:0];
        CFG_HIGH_MODULUS:   cfg.high_modulus   <= cfg_data[RES_W-1:0];
        CFG_LOW_PART_WIDTH: cfg.low_part_width <= cfg_data[LPW_W-1:0];
        CFG_HASH_WIDTH:     cfg.hash_width     <= cfg_data[HW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  wmh_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (push),
    .push_op  (push_op)
  );

  wmh_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .full    (q_full),
    .empty   (q_empty)
  );

  wmh_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .empty    (q_empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

FILE: bench/word_modular_hash_core_test.sv
// Self-checking bench for the word modular hash core: byte streams in, hash beats checked
`timescale 1ns / 100ps

module word_modular_hash_core_test;

  localparam int CYCLE_LIMIT    = 600000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int PHASE_ITEMS    = 75;
  localparam int RANDOM_PHASES  = 8;
  localparam int MAX_DIGITS     = wmh_pkg::MAX_PAIRS;
  localparam logic [6:0] UNMAPPED = 7'd64;

  localparam logic [6:0] CHAR_CODES [0:95] = '{
    UNMAPPED, UNMAPPED, UNMAPPED, UNMAPPED, UNMAPPED, UNMAPPED, 7'd0, 7'd31,
    UNMAPPED, UNMAPPED, UNMAPPED, UNMAPPED, UNMAPPED, UNMAPPED, UNMAPPED, UNMAPPED,
    7'd2, 7'd25, 7'd20, 7'd35, 7'd54, 7'd61, 7'd40, 7'd39,
    7'd42, 7'd33, UNMAPPED, UNMAPPED, UNMAPPED, UNMAPPED, UNMAPPED, UNMAPPED,
    UNMAPPED, 7'd60, 7'd43, 7'd30, 7'd5, 7'd16, 7'd47, 7'd18,
    7'd41, 7'd36, 7'd51, 7'd6, 7'd13, 7'd56, 7'd55, 7'd58,
    7'd49, 7'd12, 7'd59, 7'd46, 7'd21, 7'd32, 7'd63, 7'd34,
    7'd57, 7'd52, 7'd3, UNMAPPED, UNMAPPED, UNMAPPED, UNMAPPED, UNMAPPED,
    UNMAPPED, 7'd22, 7'd29, 7'd8, 7'd7, 7'd10, 7'd1, 7'd28,
    7'd11, 7'd62, 7'd37, 7'd48, 7'd15, 7'd50, 7'd9, 7'd4,
    7'd19, 7'd38, 7'd45, 7'd24, 7'd23, 7'd26, 7'd17, 7'd44,
    7'd27, 7'd14, 7'd53, UNMAPPED, UNMAPPED, UNMAPPED, UNMAPPED, UNMAPPED
  };

  typedef struct packed {
    logic [31:0] hash_value;
    logic        is_trash;
  } hash_exp_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic        lst;
    logic        typed;
    logic [31:0] hash_value;
    logic        is_trash;
  } dir_row_t;

  localparam logic [31:0] TRASH_27 = 32'h07FF_FFFF;

  localparam dir_row_t DIRECTED [18] = '{
    '{8'h26, 1'b1, 1'b1, 32'h0, 1'b0},
    '{8'h01, 1'b1, 1'b1, TRASH_27, 1'b1},
    '{8'hFF, 1'b1, 1'b1, TRASH_27, 1'b1},
    '{8'h00, 1'b1, 1'b1, TRASH_27, 1'b1},
    '{8'h41, 1'b0, 1'b0, 32'h0, 1'b0},
    '{8'h42, 1'b1, 1'b0, 32'h0, 1'b0},
    '{8'h61, 1'b0, 1'b0, 32'h0, 1'b0},
    '{8'h62, 1'b0, 1'b0, 32'h0, 1'b0},
    '{8'h63, 1'b1, 1'b0, 32'h0, 1'b0},
    '{8'h61, 1'b0, 1'b0, 32'h0, 1'b0},
    '{8'hC1, 1'b1, 1'b0, 32'h0, 1'b0},
    '{8'h61, 1'b0, 1'b0, 32'h0, 1'b0},
    '{8'h80, 1'b1, 1'b1, TRASH_27, 1'b1},
    '{8'h7A, 1'b0, 1'b0, 32'h0, 1'b0},
    '{8'h7F, 1'b1, 1'b1, TRASH_27, 1'b1},
    '{8'h10, 1'b0, 1'b0, 32'h0, 1'b0},
    '{8'h61, 1'b1, 1'b1, TRASH_27, 1'b1},
    '{8'h20, 1'b1, 1'b1, TRASH_27, 1'b1}
  };

  // low modulus, high modulus, low part width, hash width
  localparam logic [13:0] EDGE_SETTINGS [4][4] = '{
    '{14'd2, 14'd3, 14'd1, 14'd1},
    '{14'd16383, 14'd16383, 14'd14, 14'd32},
    '{14'd0, 14'd1, 14'd0, 14'd0},
    '{14'd16381, 14'd8191, 14'd15, 14'd63}
  };

  localparam logic [wmh_pkg::CFG_IDX_W-1:0] REG_ORDER [4] = '{
    wmh_pkg::CFG_LOW_MODULUS, wmh_pkg::CFG_HIGH_MODULUS,
    wmh_pkg::CFG_LOW_PART_WIDTH, wmh_pkg::CFG_HASH_WIDTH
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;    // [7:0] char_code
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;            // [31:0] hash_value
  logic        m_tuser;            // [0] is_trash
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [wmh_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [wmh_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // predictor copy of registers and word state
  logic [13:0] low_mod, high_mod;
  logic [3:0]  high_shift;
  logic [5:0]  trash_bits;
  logic [5:0]  pend_code;
  logic        pend_full;
  int          digit_count;
  logic [13:0] low_acc, high_acc, low_pow, high_pow;
  logic        word_spoilt;

  hash_exp_t   hash_due[$];
  logic [7:0]  mapped_chars[$];
  int          cycle_count = 0;
  int          mismatches = 0;
  int          rx_wait = 0;
  bit          rx_quiet = 1'b0;
  bit          tx_quiet = 1'b0;
  int          bytes_sent = 0;
  int          words_done = 0;
  int          trash_done = 0;
  int          settings_run = 0;

  word_modular_hash_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [6:0] code_of(input logic [7:0] ch);
    if (ch < 8'h20 || ch > 8'h7F) return UNMAPPED;
    return CHAR_CODES[int'(ch) - 32];
  endfunction

  function automatic int draw_wait(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 19);
  endfunction

  task automatic clear_word();
    pend_code = '0;
    pend_full = 1'b0;
    digit_count = 0;
    low_acc = '0;
    high_acc = '0;
    low_pow = 14'd1;
    high_pow = 14'd8;
    word_spoilt = 1'b0;
  endtask

  task automatic add_digit(input logic [11:0] d);
    longint unsigned lm, hm;
    lm = (low_mod == '0) ? 64'd1 : 64'(low_mod);
    hm = (high_mod == '0) ? 64'd1 : 64'(high_mod);
    low_acc = 14'((64'(low_acc) + 64'(d) * 64'(low_pow)) % lm);
    high_acc = 14'((64'(high_acc) + 64'(d) * 64'(high_pow)) % hm);
    low_pow = 14'((64'(low_pow) << 12) % lm);
    high_pow = 14'((64'(high_pow) << 12) % hm);
    digit_count++;
  endtask

  task automatic take_lead(input logic [7:0] ch);
    logic [6:0] c;
    if (!word_spoilt && digit_count < MAX_DIGITS) begin
      c = code_of(ch);
      if (c == UNMAPPED) begin
        word_spoilt = 1'b1;
      end else begin
        pend_code = c[5:0];
        pend_full = 1'b1;
      end
    end
  endtask

  task automatic fold_char(input logic [7:0] ch, input logic lst, output bit has_res,
                           output hash_exp_t res);
    logic [6:0] c;
    int w;
    has_res = lst;
    res = '0;
    if (!word_spoilt) begin
      if (pend_full) begin
        if (ch[6:0] == 7'd0) begin
          add_digit({6'd0, pend_code});
          pend_full = 1'b0;
          take_lead(ch);
        end else begin
          c = code_of({1'b0, ch[6:0]});
          if (c == UNMAPPED) begin
            word_spoilt = 1'b1;
          end else begin
            add_digit({c[5:0], pend_code});
            pend_full = 1'b0;
          end
        end
      end else begin
        take_lead(ch);
      end
    end
    if (lst) begin
      if (!word_spoilt && pend_full) add_digit({6'd0, pend_code});
      if (word_spoilt) begin
        w = (trash_bits > 6'd32) ? 32 : int'(trash_bits);
        res.hash_value = 32'((64'd1 << w) - 64'd1);
        res.is_trash = 1'b1;
      end else begin
        res.hash_value = 32'(64'(low_acc) | (64'(high_acc) << high_shift));
        res.is_trash = 1'b0;
      end
      clear_word();
    end
  endtask

  task automatic send_char(input logic [7:0] ch, input logic lst, input bit typed,
                           input hash_exp_t typed_res, output bit counted);
    int gap;
    bit has_res;
    hash_exp_t res;
    gap = draw_wait(tx_quiet);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= ch;
    s_tlast <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    counted = lst || !(word_spoilt || (digit_count >= MAX_DIGITS && !pend_full));
    bytes_sent++;
    fold_char(ch, lst, has_res, res);
    if (has_res) hash_due.push_back(typed ? typed_res : res);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (hash_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [13:0] lo, input logic [13:0] hi,
                                input logic [13:0] lpw, input logic [13:0] hw);
    logic [13:0] vals [4];
    vals = '{lo, hi, lpw, hw};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= REG_ORDER[i];
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (REG_ORDER[i])
        wmh_pkg::CFG_LOW_MODULUS:    low_mod = vals[i];
        wmh_pkg::CFG_HIGH_MODULUS:   high_mod = vals[i];
        wmh_pkg::CFG_LOW_PART_WIDTH: high_shift = vals[i][3:0];
        wmh_pkg::CFG_HASH_WIDTH:     trash_bits = vals[i][5:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    settings_run++;
  endtask

  function automatic logic [7:0] pick_mapped();
    return mapped_chars[$urandom_range(0, mapped_chars.size() - 1)];
  endfunction

  task automatic send_random_word(output int n_counted);
    logic [7:0] word_q[$];
    logic [7:0] b;
    int kind, len;
    bit c;
    kind = $urandom_range(0, 99);
    n_counted = 0;
    if ($urandom_range(0, 5) == 0) tx_quiet = !tx_quiet;
    if (kind < 65) begin
      if (kind < 55) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 14);
      end else begin
        len = $urandom_range(64, 70);
      end
      for (int i = 0; i < len; i++) begin
        if (i >= 64) begin
          b = 8'($urandom_range(0, 255));
        end else if (kind >= 55 && i == 63) begin
          // lone digit fills the last pair slot, so the masked-zero byte is dropped
          b = $urandom_range(0, 1) ? 8'h80 : 8'h00;
        end else begin
          b = pick_mapped();
          if (i % 2 == 1 && $urandom_range(0, 3) == 0) b[7] = 1'b1;
        end
        word_q.push_back(b);
      end
    end else if (kind < 88) begin
      len = $urandom_range(2, 12);
      for (int i = 0; i < len; i++) word_q.push_back(pick_mapped());
      if (kind < 75) begin
        word_q[1 + 2 * $urandom_range(0, (len - 2) / 2)] =
          $urandom_range(0, 1) ? 8'h80 : 8'h00;
      end else begin
        word_q[$urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
      end
    end else begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) word_q.push_back(8'($urandom_range(0, 255)));
    end
    foreach (word_q[i]) begin
      send_char(word_q[i], i == word_q.size() - 1, 1'b0, '0, c);
      n_counted += c;
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, hash_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    hash_exp_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (hash_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result beat: hash %h trash %b", m_tdata, m_tuser);
        end else begin
          want = hash_due.pop_front();
          words_done++;
          if (want.is_trash) trash_done++;
          if (m_tdata !== want.hash_value || m_tuser !== want.is_trash) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Result %0d mismatch: hash %h trash %b, wanted hash %h trash %b",
                       words_done, m_tdata, m_tuser, want.hash_value, want.is_trash);
          end
        end
        if ($urandom_range(0, 19) == 0) rx_quiet = !rx_quiet;
        rx_wait = draw_wait(rx_quiet);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      m_tready <= (rx_wait == 0);
    end
  end

  initial begin
    int n, phase_items;
    bit c;
    for (int b = 8'h20; b <= 8'h7F; b++)
      if (code_of(8'(b)) != UNMAPPED) mapped_chars.push_back(8'(b));
    low_mod = wmh_pkg::LOW_MODULUS_RST;
    high_mod = wmh_pkg::HIGH_MODULUS_RST;
    high_shift = wmh_pkg::LOW_PART_WIDTH_RST;
    trash_bits = wmh_pkg::HASH_WIDTH_RST;
    clear_word();

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i])
      send_char(DIRECTED[i].ch, DIRECTED[i].lst, DIRECTED[i].typed,
                '{DIRECTED[i].hash_value, DIRECTED[i].is_trash}, c);
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p < 4) begin
        apply_settings(EDGE_SETTINGS[p][0], EDGE_SETTINGS[p][1],
                       EDGE_SETTINGS[p][2], EDGE_SETTINGS[p][3]);
      end else begin
        // junk above the field width of the narrow registers
        apply_settings(14'($urandom_range(2, 16383)), 14'($urandom_range(2, 16383)),
                       14'({$urandom_range(0, 1023), 4'($urandom_range(1, 14))}),
                       14'({$urandom_range(0, 255), 6'($urandom_range(1, 32))}));
      end
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        send_random_word(n);
        phase_items += n;
      end
      settle();
    end

    $display("Run covered %0d bytes in %0d words (%0d trash) under %0d register settings",
             bytes_sent, words_done, trash_done, settings_run + 1);
    $display("Mismatches seen: %0d", mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
